@@ hdl/char_lcd_4bit_controller_macros.svh @@
// ----------------------------------------------------------------------------
// Character LCD controller assertion macros
// Concurrent check helpers for the controller, sampled on clk_i, off in reset.
// ----------------------------------------------------------------------------
`ifndef CHAR_LCD_4BIT_CONTROLLER_MACROS_SVH
`define CHAR_LCD_4BIT_CONTROLLER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CLCD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CLCD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/clcd_pkg.sv @@
// ----------------------------------------------------------------------------
// clcd_pkg
// Types, codes and sequencing functions shared by the character LCD controller.
// ----------------------------------------------------------------------------
`default_nettype none

package clcd_pkg;

  // Sequencer phases
  localparam logic [2:0] PH_POWER  = 3'd0;
  localparam logic [2:0] PH_EHIGH  = 3'd1;
  localparam logic [2:0] PH_SETTLE = 3'd2;
  localparam logic [2:0] PH_GAP    = 3'd3;
  localparam logic [2:0] PH_CLEAR  = 3'd4;
  localparam logic [2:0] PH_IDLE   = 3'd5;

  // Sequence steps
  localparam logic [3:0] STEP_FIRST_SYNC  = 4'd0;
  localparam logic [3:0] STEP_FIRST_BYTE  = 4'd4;
  localparam logic [3:0] STEP_INIT_CLEAR  = 4'd6;
  localparam logic [3:0] STEP_LAST_INIT   = 4'd8;
  localparam logic [3:0] STEP_USER        = 4'd9;
  localparam logic [3:0] STEP_USER_CLEAR  = 4'd10;

  // Request codes
  localparam logic [2:0] FUNC_TICK   = 3'd0;
  localparam logic [2:0] FUNC_CHAR   = 3'd1;
  localparam logic [2:0] FUNC_CMD    = 3'd2;
  localparam logic [2:0] FUNC_CURSOR = 3'd3;
  localparam logic [2:0] FUNC_CLEAR  = 3'd4;

  // Configuration register indexes
  localparam logic [2:0] CFG_ENABLE_HIGH = 3'd0;
  localparam logic [2:0] CFG_SETTLE      = 3'd1;
  localparam logic [2:0] CFG_BYTE_GAP    = 3'd2;
  localparam logic [2:0] CFG_CLEAR_WAIT  = 3'd3;
  localparam logic [2:0] CFG_POWER_UP    = 3'd4;
  localparam logic [2:0] CFG_FIRST_SYNC  = 3'd5;
  localparam logic [2:0] CFG_SYNC_WAIT   = 3'd6;

  localparam logic [7:0] CMD_CLEAR    = 8'h01;
  localparam logic [7:0] CMD_SET_ADDR = 8'h80;

  // Phase completions skipped within one item before its tick
  localparam int unsigned SKIP_DEPTH = 4;

  typedef struct packed {
    logic [15:0] enable_high_ticks;
    logic [15:0] enable_settle_ticks;
    logic [15:0] byte_gap_ticks;
    logic [15:0] clear_wait_ticks;
    logic [15:0] power_up_ticks;
    logic [15:0] first_sync_wait_ticks;
    logic [15:0] sync_wait_ticks;
  } clcd_cfg_t;

  typedef struct packed {
    logic [3:0]  init_step;
    logic [2:0]  sub_phase;
    logic [15:0] wait_counter;
    logic [7:0]  held_byte;
    logic        held_rs;
    logic        low_nibble_next;
    logic        is_ready;
  } clcd_state_t;

  typedef struct packed {
    logic       accepted;
    logic       ready_res;
    logic [3:0] data_pins;
    logic       e_pin;
    logic       rs_pin;
  } clcd_result_t;

  function automatic logic [7:0] init_item(logic [3:0] step);
    logic [7:0] b;
    case (step)
      4'd0, 4'd1, 4'd2: b = 8'h03;
      4'd3:             b = 8'h02;
      4'd4:             b = 8'h28;
      4'd5:             b = 8'h08;
      4'd6:             b = 8'h01;
      4'd7:             b = 8'h06;
      4'd8:             b = 8'h0C;
      default:          b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [6:0] row_offset(logic [1:0] row);
    logic [6:0] off;
    case (row)
      2'd0:    off = 7'h00;
      2'd1:    off = 7'h40;
      2'd2:    off = 7'h14;
      default: off = 7'h54;
    endcase
    return off;
  endfunction

  function automatic logic [15:0] phase_len(clcd_state_t st, clcd_cfg_t cfg);
    logic [15:0] len;
    case (st.sub_phase)
      PH_POWER:  len = cfg.power_up_ticks;
      PH_EHIGH:  len = (cfg.enable_high_ticks == 16'd0) ? 16'd1 : cfg.enable_high_ticks;
      PH_SETTLE: len = cfg.enable_settle_ticks;
      PH_GAP: begin
        if (st.init_step == STEP_FIRST_SYNC)      len = cfg.first_sync_wait_ticks;
        else if (st.init_step < STEP_FIRST_BYTE)  len = cfg.sync_wait_ticks;
        else                                      len = cfg.byte_gap_ticks;
      end
      PH_CLEAR:  len = cfg.clear_wait_ticks;
      default:   len = 16'd1;
    endcase
    return len;
  endfunction

  function automatic clcd_state_t start_byte(clcd_state_t st, logic [7:0] b, logic rs);
    clcd_state_t ns;
    ns                 = st;
    ns.held_byte       = b;
    ns.held_rs         = rs;
    ns.low_nibble_next = 1'b0;
    ns.sub_phase       = PH_EHIGH;
    ns.wait_counter    = 16'd0;
    return ns;
  endfunction

  function automatic clcd_state_t next_item(clcd_state_t st);
    clcd_state_t ns;
    ns = st;
    if (st.init_step < STEP_LAST_INIT) begin
      ns.init_step = 4'(st.init_step + 4'd1);
      ns = start_byte(ns, init_item(ns.init_step), 1'b0);
    end else begin
      ns.is_ready     = 1'b1;
      ns.sub_phase    = PH_IDLE;
      ns.wait_counter = 16'd0;
    end
    return ns;
  endfunction

  function automatic clcd_state_t finish_phase(clcd_state_t st);
    clcd_state_t ns;
    ns              = st;
    ns.wait_counter = 16'd0;
    case (st.sub_phase)
      PH_POWER: begin
        ns.init_step = STEP_FIRST_SYNC;
        ns = start_byte(ns, init_item(STEP_FIRST_SYNC), 1'b0);
      end
      PH_EHIGH:  ns.sub_phase = PH_SETTLE;
      PH_SETTLE: begin
        if (st.init_step >= STEP_FIRST_BYTE && !st.low_nibble_next) begin
          ns.low_nibble_next = 1'b1;
          ns.sub_phase       = PH_EHIGH;
        end else begin
          ns.sub_phase = PH_GAP;
        end
      end
      PH_GAP: begin
        if (st.init_step == STEP_INIT_CLEAR || st.init_step == STEP_USER_CLEAR) begin
          ns.sub_phase = PH_CLEAR;
        end else begin
          ns = next_item(ns);
        end
      end
      PH_CLEAR:  ns = next_item(ns);
      default: begin
        ns.is_ready  = 1'b1;
        ns.sub_phase = PH_IDLE;
      end
    endcase
    return ns;
  endfunction

endpackage

`default_nettype wire

@@ hdl/char_lcd_4bit_controller.sv @@
// ----------------------------------------------------------------------------
// char_lcd_4bit_controller
// Character LCD driver for a 4-bit parallel bus, one stream item per time tick.
//
// Every input item is one tick of the display timing and may carry a request
// (tuser: 0 tick only, 1 write character, 2 write command, 3 set cursor,
// 4 clear). Every input item produces exactly one output item holding the pin
// levels for that tick (RS, E, D4..D7), the ready flag and whether the request
// was taken. After reset the block runs the power-up wait and the 4-bit init
// sequence, then raises ready; requests arriving while not ready are dropped
// with accepted low. Items pass an input register, one pass of sequencer logic
// that resolves up to five chained phase completions, and a result register;
// one item is taken per cycle unless m_axis_tready stalls. The only loop is the
// sequencer state register, updated once per item. There is no clearing pass
// after reset. Timing registers may only be written while no item is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

`include "char_lcd_4bit_controller_macros.svh"

module char_lcd_4bit_controller
  import clcd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration write port
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_wdata_i,
  // Tick / request stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // data[7:0], row[9:8], col[15:10]
  input  wire logic [2:0]  s_axis_tuser,  // func[2:0]
  // Pin / status stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata   // rs_pin[0], e_pin[1], data_pins[5:2],
                                          // ready_res[6], accepted[7]
);

  clcd_cfg_t    cfg;
  clcd_state_t  st_q;
  clcd_state_t  st_d;
  clcd_result_t res;

  // Input register
  logic        in_valid_q;
  logic [2:0]  in_func_q;
  logic [7:0]  in_data_q;
  logic [1:0]  in_row_q;
  logic [5:0]  in_col_q;

  // Result register
  logic         out_valid_q;
  clcd_result_t out_res_q;

  logic advance;

  clcd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  clcd_seq u_seq (
    .cfg_i  (cfg),
    .st_i   (st_q),
    .func_i (in_func_q),
    .data_i (in_data_q),
    .row_i  (in_row_q),
    .col_i  (in_col_q),
    .st_o   (st_d),
    .res_o  (res)
  );

  // Move the held item into the result register when that slot frees up
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_func_q <= s_axis_tuser;
      in_data_q <= s_axis_tdata[7:0];
      in_row_q  <= s_axis_tdata[9:8];
      in_col_q  <= s_axis_tdata[15:10];
    end
  end

  // Sequencer state: advance one tick per item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.init_step       <= STEP_FIRST_SYNC;
      st_q.sub_phase       <= PH_POWER;
      st_q.wait_counter    <= 16'd0;
      st_q.held_byte       <= 8'd0;
      st_q.held_rs         <= 1'b0;
      st_q.low_nibble_next <= 1'b0;
      st_q.is_ready        <= 1'b0;
    end else if (advance) begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_res_q;

  // Ready only ever sits in the idle phase
  `CLCD_ASSERT_SAME(a_ready_idle, st_q.is_ready, st_q.sub_phase == PH_IDLE, "ready outside idle phase")
  // Sequencer must hold while no item moves through
  `CLCD_ASSERT_NEXT(a_state_hold, !advance, $stable(st_q), "sequencer moved without an item")
  // A taken request leaves the block busy
  `CLCD_ASSERT_SAME(a_acc_busy, m_axis_tvalid && out_res_q.accepted, !out_res_q.ready_res, "ready right after accept")
  // Enable strobe never shows while ready
  `CLCD_ASSERT_SAME(a_e_busy, m_axis_tvalid && out_res_q.e_pin, !out_res_q.ready_res, "E high while ready")

endmodule

`default_nettype wire

@@ hdl/clcd_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// clcd_cfg_regs
// Timing registers of the LCD controller, written through a plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module clcd_cfg_regs
  import clcd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_wdata_i,
  output clcd_cfg_t        cfg_o
);

  clcd_cfg_t cfg_q;
  clcd_cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ENABLE_HIGH: cfg_d.enable_high_ticks     = cfg_wdata_i;
        CFG_SETTLE:      cfg_d.enable_settle_ticks   = cfg_wdata_i;
        CFG_BYTE_GAP:    cfg_d.byte_gap_ticks        = cfg_wdata_i;
        CFG_CLEAR_WAIT:  cfg_d.clear_wait_ticks      = cfg_wdata_i;
        CFG_POWER_UP:    cfg_d.power_up_ticks        = cfg_wdata_i;
        CFG_FIRST_SYNC:  cfg_d.first_sync_wait_ticks = cfg_wdata_i;
        CFG_SYNC_WAIT:   cfg_d.sync_wait_ticks       = cfg_wdata_i;
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable_high_ticks     <= 16'd5;
      cfg_q.enable_settle_ticks   <= 16'd300;
      cfg_q.byte_gap_ticks        <= 16'd50;
      cfg_q.clear_wait_ticks      <= 16'd2000;
      cfg_q.power_up_ticks        <= 16'd50000;
      cfg_q.first_sync_wait_ticks <= 16'd5000;
      cfg_q.sync_wait_ticks       <= 16'd150;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

@@ hdl/clcd_seq.sv @@
// ----------------------------------------------------------------------------
// clcd_seq
// One-tick step of the LCD sequencer: take a request, resolve phases, drive pins.
// ----------------------------------------------------------------------------
`default_nettype none

module clcd_seq
  import clcd_pkg::*;
(
  input  wire clcd_cfg_t     cfg_i,
  input  wire clcd_state_t   st_i,
  input  wire logic [2:0]    func_i,
  input  wire logic [7:0]    data_i,
  input  wire logic [1:0]    row_i,
  input  wire logic [5:0]    col_i,
  output clcd_state_t        st_o,
  output clcd_result_t       res_o
);

  always_comb begin
    clcd_state_t st;
    logic        acc;
    logic [6:0]  addr;
    logic [16:0] cnt;
    logic [3:0]  nib;

    st   = st_i;
    acc  = 1'b0;
    addr = 7'({1'b0, col_i}) + row_offset(row_i);

    // Take a request only while ready
    if (st.is_ready && func_i >= FUNC_CHAR && func_i <= FUNC_CLEAR) begin
      acc         = 1'b1;
      st.is_ready = 1'b0;
      st.init_step = (func_i == FUNC_CLEAR) ? STEP_USER_CLEAR : STEP_USER;
      case (func_i)
        FUNC_CHAR:   st = start_byte(st, data_i, 1'b1);
        FUNC_CMD:    st = start_byte(st, data_i, 1'b0);
        FUNC_CURSOR: st = start_byte(st, CMD_SET_ADDR | {1'b0, addr}, 1'b0);
        default:     st = start_byte(st, CMD_CLEAR, 1'b0);
      endcase
    end

    // Skip phases that are already used up (zero length or shortened)
    for (int i = 0; i < SKIP_DEPTH; i++) begin
      if (!st.is_ready && phase_len(st, cfg_i) <= st.wait_counter) begin
        st = finish_phase(st);
      end
    end

    if (st.init_step < STEP_FIRST_BYTE) nib = st.held_byte[3:0];
    else nib = st.low_nibble_next ? st.held_byte[3:0] : st.held_byte[7:4];

    res_o.rs_pin    = st.held_rs;
    res_o.e_pin     = (st.sub_phase == PH_EHIGH);
    res_o.data_pins = nib;

    // Advance by one tick
    if (!st.is_ready) begin
      cnt             = {1'b0, st.wait_counter} + 17'd1;
      st.wait_counter = cnt[15:0];
      if (cnt >= {1'b0, phase_len(st, cfg_i)}) begin
        st = finish_phase(st);
      end
    end

    res_o.ready_res = st.is_ready;
    res_o.accepted  = acc;
    st_o            = st;
  end

endmodule

`default_nettype wire
